>>> sv/grid_bfs_distance_transform_macros.svh
// Assertion macros for the grid distance transform block.
// Included by the RTL files that carry concurrent assertions.
`ifndef GRID_BFS_DISTANCE_TRANSFORM_MACROS_SVH
`define GRID_BFS_DISTANCE_TRANSFORM_MACROS_SVH

`ifndef ASSERT_OFF
// Checked property with a synchronous reset that disables it.
`define GBDT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that holds through reset as well.
`define GBDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GBDT_ASSERT(lbl, clk, rst, prop, msg)
`define GBDT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> sv/gbdt_pkg.sv
// Shared types, constants and helpers of the grid distance transform.
// No dependencies; used by the top level.
`default_nettype none

package gbdt_pkg;

   localparam int GRID_W    = 128;
   localparam int GRID_H    = 128;
   localparam int CELLS     = GRID_W * GRID_H;
   localparam int CELL_BITS = $clog2(CELLS);
   // Coordinate width: holds any grid extent plus one, and any 8-bit input.
   localparam int CW        = 11;
   localparam int COST_W    = 8;
   localparam int DIST_W    = 15;
   localparam int DIST_MAX  = 16383;

   typedef enum logic [2:0] {
      OP_WRITE_COST  = 3'd0,
      OP_CLEAR       = 3'd1,
      OP_ADD_SEED    = 3'd2,
      OP_SEED_OBST   = 3'd3,
      OP_PROPAGATE   = 3'd4,
      OP_READ_DIST   = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      REG_ACTIVE_WIDTH  = 2'd0,
      REG_ACTIVE_HEIGHT = 2'd1,
      REG_OBST_THRESH   = 2'd2
   } reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SEED_CHK,
      ST_SOB_RD,
      ST_SOB_CHK,
      ST_POP,
      ST_CELL,
      ST_CENTRE,
      ST_NB_RD,
      ST_NB_CHK,
      ST_READ_OUT,
      ST_DONE
   } state_type;

   // Linear cell address of a column and row inside the grid.
   function automatic logic [CELL_BITS-1:0] cell_index(input logic [CW-1:0] x,
                                                      input logic [CW-1:0] y);
      cell_index = CELL_BITS'(y * GRID_W + x);
   endfunction

endpackage

`default_nettype wire

>>> sv/grid_bfs_distance_transform.sv
// Grid distance transform: 8-connected breadth-first step distances.
// Depends on gbdt_pkg, gbdt_ram and grid_bfs_distance_transform_macros.svh.
//
// Usage: drive req_operation, req_x_coord, req_y_coord and req_cell_cost
// and raise start; the item is taken at the edge where start is high and
// busy is low. Exactly one result follows per item, shown for one cycle
// with rsp_valid high; the receiver cannot stall it. Registers are written
// on the csr_ channel (index 0 width, 1 height, 2 obstacle threshold),
// which is always ready; the user is to use it only while the block is
// idle, which the block does not enforce. Up to the result strobe, after
// which busy falls, write cost writes at the transfer, unused codes and
// out-of-grid add seed or read distance do nothing, add seed reads and
// checks its cell, read distance reads it, clear writes one distance entry
// per cycle, seed obstacles reads and checks every active cell, and
// propagate pops each queued cell, drops it if outside the grid, else reads
// its distance, then reads and checks each in-grid neighbour. The distance
// RAM has one write port, so every neighbour update takes a read state and
// a check/write state; that loop sets the propagate rate. After reset the
// block runs a clearing pass over all 16384 distance entries with busy high
// and no result; the register channel still takes transfers then.
`default_nettype none
`include "grid_bfs_distance_transform_macros.svh"

module grid_bfs_distance_transform (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [2:0]           req_operation,
   input  wire logic [7:0]           req_x_coord,
   input  wire logic [7:0]           req_y_coord,
   input  wire logic [7:0]           req_cell_cost,
   output logic                      rsp_valid,
   output logic                      rsp_status,
   output logic signed [14:0]        rsp_distance,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [1:0]           csr_index,
   input  wire logic [7:0]           csr_data
);

   localparam int CB = gbdt_pkg::CELL_BITS;
   localparam int CW = gbdt_pkg::CW;
   localparam int DW = gbdt_pkg::DIST_W;

   gbdt_pkg::state_type state_ff, state_in;

   logic [7:0]    width_ff, height_ff, thresh_ff;
   logic          status_ff, status_in;
   logic [DW-1:0] dist_ff, dist_in;
   logic [CB-1:0] addr_ff, addr_in;
   logic [CW-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [2:0]    nb_ff, nb_in;
   logic [DW-1:0] nd_ff, nd_in;
   logic [CB:0]   head_ff, head_in, tail_ff, tail_in;
   logic [CB-1:0] clr_cnt_ff, clr_cnt_in;
   logic          clr_rsp_ff, clr_rsp_in;

   // Memory ports.
   logic          cost_we, dist_we, q_we;
   logic [CB-1:0] cost_wa, dist_wa, rd_addr;
   logic [7:0]    cost_wd, cost_rdata;
   logic [DW-1:0] dist_wd, dist_rdata;
   logic [CB-1:0] q_rdata;

   // Shared decode.
   logic [CW-1:0] ext_w, ext_h, req_x, req_y, q_cx, q_cy, nx, ny, sx_next;
   logic          req_inside, q_inside, q_pending, nb_ok, nb_last, nb_take;
   logic          sob_last, sob_hit, tail_room;
   logic          dxm, dxp, dym, dyp;
   logic [CB-1:0] req_idx, nb_idx;

   assign ext_w = (CW'(width_ff) > CW'(gbdt_pkg::GRID_W)) ?
                  CW'(gbdt_pkg::GRID_W) : CW'(width_ff);
   assign ext_h = (CW'(height_ff) > CW'(gbdt_pkg::GRID_H)) ?
                  CW'(gbdt_pkg::GRID_H) : CW'(height_ff);

   assign req_x      = CW'(req_x_coord);
   assign req_y      = CW'(req_y_coord);
   assign req_inside = (req_x < ext_w) && (req_y < ext_h);
   assign req_idx    = gbdt_pkg::cell_index(req_x, req_y);

   assign q_cx      = CW'(q_rdata % gbdt_pkg::GRID_W);
   assign q_cy      = CW'(q_rdata / gbdt_pkg::GRID_W);
   assign q_inside  = (q_cx < ext_w) && (q_cy < ext_h);
   assign q_pending = head_ff < tail_ff;
   assign tail_room = tail_ff < (CB+1)'(gbdt_pkg::CELLS);

   // Neighbour offsets, column outer and row inner, as the flood expects.
   always_comb begin
      unique case (nb_ff)
         3'd0:    {dxm, dxp, dym, dyp} = 4'b1010;
         3'd1:    {dxm, dxp, dym, dyp} = 4'b1000;
         3'd2:    {dxm, dxp, dym, dyp} = 4'b1001;
         3'd3:    {dxm, dxp, dym, dyp} = 4'b0010;
         3'd4:    {dxm, dxp, dym, dyp} = 4'b0001;
         3'd5:    {dxm, dxp, dym, dyp} = 4'b0110;
         3'd6:    {dxm, dxp, dym, dyp} = 4'b0100;
         default: {dxm, dxp, dym, dyp} = 4'b0101;
      endcase
   end

   assign nx      = dxm ? cx_ff - CW'(1) : (dxp ? cx_ff + CW'(1) : cx_ff);
   assign ny      = dym ? cy_ff - CW'(1) : (dyp ? cy_ff + CW'(1) : cy_ff);
   assign nb_ok   = !(dxm && (cx_ff == '0)) && !(dym && (cy_ff == '0)) &&
                    (nx < ext_w) && (ny < ext_h);
   assign nb_idx  = gbdt_pkg::cell_index(nx, ny);
   assign nb_last = (nb_ff == 3'd7);
   assign nb_take = dist_rdata[DW-1] && (cost_rdata < thresh_ff);

   assign sob_last = ((sx_ff + CW'(1)) >= ext_w) && ((sy_ff + CW'(1)) >= ext_h);
   assign sob_hit  = (cost_rdata >= thresh_ff) && (dist_rdata != '0);
   assign sx_next  = sx_ff + CW'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gbdt_pkg::ST_IDLE: begin
            if (start) begin
               unique case (req_operation)
                  gbdt_pkg::OP_CLEAR:     state_in = gbdt_pkg::ST_CLEAR;
                  gbdt_pkg::OP_ADD_SEED:
                     state_in = req_inside ? gbdt_pkg::ST_SEED_CHK : gbdt_pkg::ST_DONE;
                  gbdt_pkg::OP_SEED_OBST:
                     state_in = ((ext_w == '0) || (ext_h == '0)) ?
                                gbdt_pkg::ST_DONE : gbdt_pkg::ST_SOB_RD;
                  gbdt_pkg::OP_PROPAGATE: state_in = gbdt_pkg::ST_POP;
                  gbdt_pkg::OP_READ_DIST:
                     state_in = req_inside ? gbdt_pkg::ST_READ_OUT : gbdt_pkg::ST_DONE;
                  default:                state_in = gbdt_pkg::ST_DONE;
               endcase
            end
         end
         gbdt_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == CB'(gbdt_pkg::CELLS - 1)) begin
               state_in = clr_rsp_ff ? gbdt_pkg::ST_DONE : gbdt_pkg::ST_IDLE;
            end
         end
         gbdt_pkg::ST_SEED_CHK: state_in = gbdt_pkg::ST_DONE;
         gbdt_pkg::ST_SOB_RD:   state_in = gbdt_pkg::ST_SOB_CHK;
         gbdt_pkg::ST_SOB_CHK:
            state_in = sob_last ? gbdt_pkg::ST_DONE : gbdt_pkg::ST_SOB_RD;
         gbdt_pkg::ST_POP:
            state_in = q_pending ? gbdt_pkg::ST_CELL : gbdt_pkg::ST_DONE;
         gbdt_pkg::ST_CELL:
            state_in = q_inside ? gbdt_pkg::ST_CENTRE : gbdt_pkg::ST_POP;
         gbdt_pkg::ST_CENTRE:   state_in = gbdt_pkg::ST_NB_RD;
         gbdt_pkg::ST_NB_RD: begin
            if (nb_ok) begin
               state_in = gbdt_pkg::ST_NB_CHK;
            end else if (nb_last) begin
               state_in = gbdt_pkg::ST_POP;
            end
         end
         gbdt_pkg::ST_NB_CHK:
            state_in = nb_last ? gbdt_pkg::ST_POP : gbdt_pkg::ST_NB_RD;
         gbdt_pkg::ST_READ_OUT: state_in = gbdt_pkg::ST_DONE;
         gbdt_pkg::ST_DONE:     state_in = gbdt_pkg::ST_IDLE;
         default:               state_in = gbdt_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      status_in  = status_ff;
      dist_in    = dist_ff;
      addr_in    = addr_ff;
      sx_in      = sx_ff;
      sy_in      = sy_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      nb_in      = nb_ff;
      nd_in      = nd_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      clr_cnt_in = clr_cnt_ff;
      clr_rsp_in = clr_rsp_ff;
      cost_we    = 1'b0;
      cost_wa    = req_idx;
      cost_wd    = req_cell_cost;
      dist_we    = 1'b0;
      dist_wa    = addr_ff;
      dist_wd    = '0;
      q_we       = 1'b0;
      rd_addr    = req_idx;
      unique case (state_ff)
         gbdt_pkg::ST_IDLE: begin
            if (start) begin
               status_in = 1'b0;
               dist_in   = '0;
               addr_in   = req_idx;
               sx_in     = '0;
               sy_in     = '0;
               unique case (req_operation)
                  gbdt_pkg::OP_WRITE_COST: begin
                     status_in = !req_inside;
                     cost_we   = req_inside;
                  end
                  gbdt_pkg::OP_CLEAR: begin
                     head_in    = '0;
                     tail_in    = '0;
                     clr_cnt_in = '0;
                     clr_rsp_in = 1'b1;
                  end
                  gbdt_pkg::OP_ADD_SEED,
                  gbdt_pkg::OP_READ_DIST: status_in = !req_inside;
                  default: ;
               endcase
            end
         end
         gbdt_pkg::ST_CLEAR: begin
            dist_we    = 1'b1;
            dist_wa    = clr_cnt_ff;
            dist_wd    = '1;
            clr_cnt_in = clr_cnt_ff + CB'(1);
         end
         gbdt_pkg::ST_SEED_CHK: begin
            if (dist_rdata != '0) begin
               dist_we = 1'b1;
               q_we    = tail_room;
               tail_in = tail_room ? tail_ff + (CB+1)'(1) : tail_ff;
            end
         end
         gbdt_pkg::ST_SOB_RD: begin
            rd_addr = gbdt_pkg::cell_index(sx_ff, sy_ff);
            addr_in = rd_addr;
         end
         gbdt_pkg::ST_SOB_CHK: begin
            if (sob_hit) begin
               dist_we = 1'b1;
               q_we    = tail_room;
               tail_in = tail_room ? tail_ff + (CB+1)'(1) : tail_ff;
            end
            if ((sy_ff + CW'(1)) < ext_h) begin
               sy_in = sy_ff + CW'(1);
            end else begin
               sy_in = '0;
               sx_in = sx_next;
            end
         end
         gbdt_pkg::ST_POP: begin
            if (q_pending) begin
               head_in = head_ff + (CB+1)'(1);
            end else begin
               head_in = '0;
               tail_in = '0;
            end
         end
         gbdt_pkg::ST_CELL: begin
            rd_addr = q_rdata;
            cx_in   = q_cx;
            cy_in   = q_cy;
         end
         gbdt_pkg::ST_CENTRE: begin
            nd_in = (dist_rdata == DW'(gbdt_pkg::DIST_MAX)) ?
                    dist_rdata : dist_rdata + DW'(1);
            nb_in = '0;
         end
         gbdt_pkg::ST_NB_RD: begin
            rd_addr = nb_idx;
            addr_in = nb_idx;
            if (!nb_ok) begin
               nb_in = nb_ff + 3'd1;
            end
         end
         gbdt_pkg::ST_NB_CHK: begin
            if (nb_take) begin
               dist_we = 1'b1;
               dist_wd = nd_ff;
               q_we    = tail_room;
               tail_in = tail_room ? tail_ff + (CB+1)'(1) : tail_ff;
            end
            nb_in = nb_ff + 3'd1;
         end
         gbdt_pkg::ST_READ_OUT: dist_in = dist_rdata;
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= gbdt_pkg::ST_CLEAR;
         head_ff    <= '0;
         tail_ff    <= '0;
         clr_cnt_ff <= '0;
         clr_rsp_ff <= 1'b0;
         width_ff   <= 8'd128;
         height_ff  <= 8'd128;
         thresh_ff  <= 8'd254;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         clr_cnt_ff <= clr_cnt_in;
         clr_rsp_ff <= clr_rsp_in;
         if (csr_valid) begin
            unique case (csr_index)
               gbdt_pkg::REG_ACTIVE_WIDTH:  width_ff  <= csr_data;
               gbdt_pkg::REG_ACTIVE_HEIGHT: height_ff <= csr_data;
               gbdt_pkg::REG_OBST_THRESH:   thresh_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      dist_ff   <= dist_in;
      addr_ff   <= addr_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      nb_ff     <= nb_in;
      nd_ff     <= nd_in;
   end

   assign busy         = (state_ff != gbdt_pkg::ST_IDLE);
   assign rsp_valid    = (state_ff == gbdt_pkg::ST_DONE);
   assign rsp_status   = status_ff;
   assign rsp_distance = dist_ff;
   assign csr_ready    = 1'b1;

   gbdt_ram #(.WIDTH(gbdt_pkg::COST_W), .DEPTH(gbdt_pkg::CELLS)) u_cost_ram (
      .clock   (clock),
      .wr_en   (cost_we),
      .wr_addr (cost_wa),
      .wr_data (cost_wd),
      .rd_addr (rd_addr),
      .rd_data (cost_rdata)
   );

   gbdt_ram #(.WIDTH(DW), .DEPTH(gbdt_pkg::CELLS)) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (dist_wa),
      .wr_data (dist_wd),
      .rd_addr (rd_addr),
      .rd_data (dist_rdata)
   );

   gbdt_ram #(.WIDTH(CB), .DEPTH(gbdt_pkg::CELLS)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (tail_ff[CB-1:0]),
      .wr_data (addr_ff),
      .rd_addr (head_ff[CB-1:0]),
      .rd_data (q_rdata)
   );

   // The result strobe lasts a single cycle.
   `GBDT_ASSERT(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid, "result strobe held")
   // A transfer always makes the block busy on the next cycle.
   `GBDT_ASSERT(a_start_busy, clock, reset, (start && !busy) |=> busy, "transfer not taken")
   // The queue read pointer never passes the write pointer.
   `GBDT_ASSERT(a_head_tail, clock, reset, head_ff <= tail_ff, "queue head beyond tail")
   // A queue write only happens while the queue has room.
   `GBDT_ASSERT(a_q_room, clock, reset, q_we |-> tail_room, "queue overflow write")

endmodule

`default_nettype wire

>>> sv/gbdt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module gbdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire
